@@ src/mec_pkg.sv @@
`default_nettype none

package mec_pkg;

    // Widths of the fixed-point words
    localparam int unsigned CoordW = 32;
    localparam int unsigned ProdW  = 64;
    localparam int unsigned CountW = 16;
    localparam int unsigned ColorW = 8;

    // Q4.28 coordinates, Q8.56 products
    localparam int unsigned FracBits = 28;

    // Escape when the Q8.56 magnitude reaches 4.0, i.e. any bit at or above 58
    localparam int unsigned EscapeBit = 58;

    localparam logic [CountW-1:0] ResetMaxIter = 16'd1000;
    localparam logic [ColorW-1:0] GreenOffset  = 8'd85;
    localparam logic [ColorW-1:0] BlueOffset   = 8'd170;

    localparam logic [CoordW-1:0] CoordMax = 32'h7FFF_FFFF;
    localparam logic [CoordW-1:0] CoordMin = 32'h8000_0000;

    // Operand pair fed to the shared multiplier
    typedef enum logic [1:0] {
        MS_RR = 2'd0,
        MS_II = 2'd1,
        MS_RI = 2'd2
    } t_mul_sel;

    // Sequencer to datapath controls
    typedef struct packed {
        logic     load;      // take a new point
        logic     cap_rr;    // product holds zr*zr
        logic     cap_diff;  // product holds zi*zi
        logic     update;    // product holds zr*zi, step z
        t_mul_sel sel;
    } t_dp_ctrl;

endpackage

`default_nettype wire

@@ src/mec_dp.sv @@
`default_nettype none

module mec_dp (
    input  wire logic                               i_clk,
    input  wire mec_pkg::t_dp_ctrl                  i_ctrl,
    input  wire logic signed [mec_pkg::CoordW-1:0]  i_c_re,
    input  wire logic signed [mec_pkg::CoordW-1:0]  i_c_im,
    output logic                                    o_escaped
);
    import mec_pkg::*;

    localparam int unsigned NrW = ProdW - FracBits + 1;      // 37
    localparam int unsigned NiW = ProdW - FracBits + 2;      // 38

    logic signed [CoordW-1:0] r_cr, r_ci, r_zr, r_zi;
    logic signed [ProdW-1:0]  r_prod, r_rr, r_diff;

    logic signed [CoordW-1:0] w_a, w_b;
    logic signed [ProdW-1:0]  w_prod;
    logic        [ProdW-1:0]  w_mag;
    logic signed [NrW-1:0]    w_nr;
    logic signed [NiW-1:0]    w_ni;
    logic signed [CoordW-1:0] w_zr_sat, w_zi_sat;

    // Shared multiplier operand select
    always_comb begin
        unique case (i_ctrl.sel)
            MS_RR:   begin w_a = r_zr; w_b = r_zr; end
            MS_II:   begin w_a = r_zi; w_b = r_zi; end
            MS_RI:   begin w_a = r_zr; w_b = r_zi; end
            default: begin w_a = r_zr; w_b = r_zr; end
        endcase
    end

    assign w_prod = ProdW'(w_a) * ProdW'(w_b);

    // |z|^2 test: both squares are non-negative, sum cannot wrap
    assign w_mag     = r_rr + r_prod;
    assign o_escaped = |w_mag[ProdW-1:EscapeBit];

    // New real part: floor((rr - ii) / 2^28) + c_re
    assign w_nr = NrW'($signed(r_diff[ProdW-1:FracBits])) + NrW'(r_cr);
    // New imaginary part: floor(zr*zi / 2^27) + c_im
    assign w_ni = NiW'($signed(r_prod[ProdW-1:FracBits-1])) + NiW'(r_ci);

    // Clamp to the signed 32-bit range
    always_comb begin
        if (w_nr[NrW-1:CoordW-1] == {(NrW-CoordW+1){w_nr[NrW-1]}}) begin
            w_zr_sat = w_nr[CoordW-1:0];
        end else begin
            w_zr_sat = w_nr[NrW-1] ? CoordMin : CoordMax;
        end
        if (w_ni[NiW-1:CoordW-1] == {(NiW-CoordW+1){w_ni[NiW-1]}}) begin
            w_zi_sat = w_ni[CoordW-1:0];
        end else begin
            w_zi_sat = w_ni[NiW-1] ? CoordMin : CoordMax;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_ctrl.load) begin
            r_cr <= i_c_re;
            r_ci <= i_c_im;
            r_zr <= i_c_re;
            r_zi <= i_c_im;
        end else if (i_ctrl.update) begin
            r_zr <= w_zr_sat;
            r_zi <= w_zi_sat;
        end
        if (i_ctrl.cap_rr) begin
            r_rr <= r_prod;
        end
        if (i_ctrl.cap_diff) begin
            r_diff <= r_rr - r_prod;
        end
    end

endmodule

`default_nettype wire

@@ src/mandelbrot_escape_colour.sv @@
// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+---------------------------------
// point     | in        | start, busy                 | i_c_re, i_c_im (Q4.28 signed)
// result    | out       | o_result_valid (strobe)     | o_escape_count, o_red/green/blue
// config    | in        | i_cfg_valid, o_cfg_ready    | i_cfg_data (max_iterations)
//
// One shared 32x32 multiplier does zr^2, zi^2 and zr*zi in turn, so an
// iteration steps through S_RR, S_II, S_RI and S_UPD; busy stays high through a
// point's final S_RI, and the result strobe comes in the cycle after that.
// A new point can be started in the same cycle as the result strobe.
// Synchronous active-low reset sets max_iterations to 1000 and idles the block.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none

module mandelbrot_escape_colour (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [mec_pkg::CoordW-1:0]  i_c_re,
    input  wire logic signed [mec_pkg::CoordW-1:0]  i_c_im,
    output logic                                    o_result_valid,
    output logic [mec_pkg::CountW-1:0]              o_escape_count,
    output logic [mec_pkg::ColorW-1:0]              o_red,
    output logic [mec_pkg::ColorW-1:0]              o_green,
    output logic [mec_pkg::ColorW-1:0]              o_blue,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mec_pkg::CountW-1:0]         i_cfg_data
);
    import mec_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RR   = 5'b00010,
        S_II   = 5'b00100,
        S_RI   = 5'b01000,
        S_UPD  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CountW-1:0]   r_count, n_count;
    logic [CountW-1:0]   r_max_iter;
    logic                r_result_valid, n_result_valid;
    logic [CountW-1:0]   r_escape_count;
    logic [ColorW-1:0]   r_red, r_green, r_blue;
    t_dp_ctrl            w_ctrl;
    logic                w_escaped;
    logic                w_finish;

    mec_dp u_dp (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_c_re    (i_c_re),
        .i_c_im    (i_c_im),
        .o_escaped (w_escaped)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Iteration stops on escape or when the count reaches the cap
    assign w_finish = (r_state == S_RI) && (w_escaped || !(r_count < r_max_iter));

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_result_valid = 1'b0;
        w_ctrl         = '{load: 1'b0, cap_rr: 1'b0, cap_diff: 1'b0,
                           update: 1'b0, sel: MS_RR};
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_ctrl.load = 1'b1;
                    n_count     = CountW'(1);
                    n_state     = S_RR;
                end
            end
            S_RR: begin
                w_ctrl.sel = MS_RR;
                n_state    = S_II;
            end
            S_II: begin
                w_ctrl.cap_rr = 1'b1;
                w_ctrl.sel    = MS_II;
                n_state       = S_RI;
            end
            S_RI: begin
                w_ctrl.cap_diff = 1'b1;
                w_ctrl.sel      = MS_RI;
                if (w_finish) begin
                    n_result_valid = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                w_ctrl.update = 1'b1;
                n_count       = r_count + CountW'(1);
                n_state       = S_RR;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and the iteration cap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= CountW'(1);
            r_result_valid <= 1'b0;
            r_max_iter     <= ResetMaxIter;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_result_valid <= n_result_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_iter <= i_cfg_data;
            end
        end
    end

    // Result registers: black when the cap was reached
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_escape_count <= r_count;
            if (r_count == r_max_iter) begin
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
            end else begin
                r_red   <= r_count[ColorW-1:0];
                r_green <= r_count[ColorW-1:0] + GreenOffset;
                r_blue  <= r_count[ColorW-1:0] + BlueOffset;
            end
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_escape_count = r_escape_count;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;

    // A result strobe only follows the escape test step
    a_strobe_after_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == S_RI))
        else $error("result strobe without a preceding escape test");

    // Strobe cycle finds the block idle
    a_idle_on_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("block busy during result strobe");

    // A started point begins its first square with a count of one
    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_RR && r_count == CountW'(1)))
        else $error("point transfer did not start iteration");

    // The count never wraps to zero
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_escape_count != '0))
        else $error("escape count of zero");

endmodule

`default_nettype wire
